@@ rtl/wlr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wlr_pkg
// Shared types, constants and the CRC8 step for the wear-leveling record log.
// ----------------------------------------------------------------------------
package wlr_pkg;

	localparam int STORE_BYTES_DEF = 512;
	localparam int MAX_DATA_DEF    = 51;

	localparam logic [7:0] HDR_BYTE   = 8'h6B;
	localparam logic [7:0] OVERHEAD   = 8'd5;
	localparam logic [7:0] CRC_INIT   = 8'hF1;
	localparam logic [7:0] CRC_POLY   = 8'hE0;
	localparam logic [7:0] CRC_XOR    = 8'hAB;
	localparam logic [7:0] FILL_RESET = 8'hFF;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_SCAN  = 2'd2;
	localparam logic [1:0] CMD_ERASE = 2'd3;

	localparam logic [2:0] ST_DATA  = 3'd0;
	localparam logic [2:0] ST_OK    = 3'd1;
	localparam logic [2:0] ST_ERR   = 3'd2;
	localparam logic [2:0] ST_BIG   = 3'd3;
	localparam logic [2:0] ST_EMPTY = 3'd4;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] data_in;
		logic       last_in;
		logic [7:0] read_size;
	} in_item_t;

	typedef struct packed {
		logic [7:0] data_out;
		logic [2:0] status;
		logic       last_out;
	} out_item_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_CLR_START, OP_ERA_START, OP_FILL, OP_BUF,
		OP_CMT_CHK, OP_CMT_RESET, OP_CMT_SETUP,
		OP_WR_HDR, OP_WR_CHI, OP_WR_CLO, OP_WR_SIZE, OP_WR_DATA, OP_WR_CRC,
		OP_CMT_DONE, OP_RD_SETUP, OP_SC_SETUP,
		OP_RD_HDR, OP_RD_CHI, OP_RD_CLO, OP_RD_RSIZE, OP_SC_SIZE,
		OP_RD_DATA, OP_SC_DATA, OP_RD_END, OP_SC_NEXT, OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [2:0] est;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       last;
		logic       rsize_big;
		logic       fill_last;
		logic       big;
		logic       wrap;
		logic       idx_done;
		logic       hdr_ok;
		logic       size_ok;
		logic       crc_ok;
		logic       base_in;
		logic       cnt_zero;
	} dp_stat_t;

	// one byte through the CRC8 shift register, MSB first
	function automatic logic [7:0] crc_step(input logic [7:0] r, input logic [7:0] b);
		logic [7:0] x;
		x = r ^ b;
		for (int i = 0; i < 8; i++) begin
			x = x[7] ? ((x << 1) ^ CRC_POLY) : (x << 1);
		end
		return x;
	endfunction

endpackage
`default_nettype wire

@@ rtl/wlr_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wlr_dp
// Datapath: byte store, write buffer, pointers, CRC and record registers.
// ----------------------------------------------------------------------------
module wlr_dp #(
	parameter int STORE_BYTES = wlr_pkg::STORE_BYTES_DEF,
	parameter int MAX_DATA    = wlr_pkg::MAX_DATA_DEF
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      accept,
	input  wire wlr_pkg::in_item_t   item,
	input  wire                      cfg_we,
	input  wire  [7:0]               cfg_wdata,
	input  wire wlr_pkg::dp_cmd_t    cmd,
	output wlr_pkg::dp_stat_t        stat,
	output logic                     valid,
	output wlr_pkg::out_item_t       result
);
	localparam int AW  = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
	localparam int PW  = $clog2(STORE_BYTES + 512);
	localparam int BW  = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
	localparam int WCW = $clog2(MAX_DATA + 2);

	logic [7:0] store_mem [STORE_BYTES];
	logic [7:0] wbuf_mem  [MAX_DATA];

	wlr_pkg::in_item_t  in_q;
	wlr_pkg::out_item_t res_q;
	logic            valid_q;
	logic [7:0]      fill_cfg_q, fillv_q, crc_q, size_q, idx_q, rlen_q;
	logic [PW-1:0]   ptr_q, base_q;
	logic [15:0]     cnt_q, rcnt_q, raddr_q;
	logic [WCW-1:0]  wcount_q;
	logic [7:0]      ram_s1, wb_s1;
	logic            inr_s1;

	logic [7:0]      rdata, crc_in, crc_nx, wbyte;
	logic            ptr_in, mem_we;
	logic [PW-1:0]   rec_end, next_base;

	assign rdata  = inr_s1 ? ram_s1 : fill_cfg_q;
	assign ptr_in = ptr_q < PW'(STORE_BYTES);

	always_comb begin
		case (cmd.op)
			wlr_pkg::OP_WR_HDR:   crc_in = wlr_pkg::HDR_BYTE;
			wlr_pkg::OP_WR_CHI:   crc_in = cnt_q[15:8];
			wlr_pkg::OP_WR_CLO:   crc_in = cnt_q[7:0];
			wlr_pkg::OP_WR_SIZE:  crc_in = size_q;
			wlr_pkg::OP_WR_DATA:  crc_in = wb_s1;
			wlr_pkg::OP_RD_RSIZE: crc_in = in_q.read_size;
			default:              crc_in = rdata;
		endcase
	end

	assign crc_nx = wlr_pkg::crc_step(crc_q, crc_in);

	always_comb begin
		case (cmd.op)
			wlr_pkg::OP_WR_CRC: wbyte = crc_q ^ wlr_pkg::CRC_XOR;
			wlr_pkg::OP_FILL:   wbyte = fillv_q;
			default:            wbyte = crc_in;
		endcase
	end

	always_comb begin
		case (cmd.op)
			wlr_pkg::OP_FILL, wlr_pkg::OP_WR_HDR, wlr_pkg::OP_WR_CHI, wlr_pkg::OP_WR_CLO,
			wlr_pkg::OP_WR_SIZE, wlr_pkg::OP_WR_DATA, wlr_pkg::OP_WR_CRC: mem_we = ptr_in;
			default: mem_we = 1'b0;
		endcase
	end

	assign rec_end   = PW'(raddr_q) + PW'(rlen_q);
	assign next_base = base_q + PW'(size_q) + PW'(wlr_pkg::OVERHEAD);

	// byte store, registered read at the pointer
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[ptr_q[AW-1:0]] <= wbyte;
		end
		ram_s1 <= store_mem[ptr_q[AW-1:0]];
		inr_s1 <= ptr_in;
	end

	// write buffer
	always_ff @(posedge clk) begin
		if (cmd.op == wlr_pkg::OP_BUF && wcount_q < WCW'(MAX_DATA)) begin
			wbuf_mem[wcount_q[BW-1:0]] <= in_q.data_in;
		end
		wb_s1 <= wbuf_mem[idx_q[BW-1:0]];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			in_q <= item;
		end
		case (cmd.op)
			wlr_pkg::OP_CLR_START: begin
				ptr_q   <= '0;
				fillv_q <= wlr_pkg::FILL_RESET;
			end
			wlr_pkg::OP_ERA_START: begin
				ptr_q   <= '0;
				fillv_q <= fill_cfg_q;
			end
			wlr_pkg::OP_FILL: ptr_q <= ptr_q + 1'b1;
			wlr_pkg::OP_CMT_CHK: size_q <= 8'(wcount_q);
			wlr_pkg::OP_CMT_SETUP: begin
				base_q <= rec_end;
				ptr_q  <= rec_end;
				cnt_q  <= rcnt_q + 16'd1;
				crc_q  <= wlr_pkg::CRC_INIT;
				idx_q  <= '0;
			end
			wlr_pkg::OP_WR_HDR, wlr_pkg::OP_WR_CHI, wlr_pkg::OP_WR_CLO,
			wlr_pkg::OP_WR_SIZE, wlr_pkg::OP_RD_HDR, wlr_pkg::OP_SC_SIZE: begin
				crc_q <= crc_nx;
				ptr_q <= ptr_q + 1'b1;
				if (cmd.op == wlr_pkg::OP_SC_SIZE) begin
					size_q <= rdata;
				end
			end
			wlr_pkg::OP_WR_DATA, wlr_pkg::OP_RD_DATA, wlr_pkg::OP_SC_DATA: begin
				crc_q <= crc_nx;
				ptr_q <= ptr_q + 1'b1;
				idx_q <= idx_q + 8'd1;
			end
			wlr_pkg::OP_WR_CRC: ptr_q <= ptr_q + 1'b1;
			wlr_pkg::OP_RD_SETUP: begin
				base_q <= PW'(raddr_q);
				ptr_q  <= PW'(raddr_q);
				crc_q  <= wlr_pkg::CRC_INIT;
				idx_q  <= '0;
			end
			wlr_pkg::OP_SC_SETUP: begin
				base_q <= '0;
				ptr_q  <= '0;
				crc_q  <= wlr_pkg::CRC_INIT;
				idx_q  <= '0;
			end
			wlr_pkg::OP_RD_CHI: begin
				crc_q        <= crc_nx;
				ptr_q        <= ptr_q + 1'b1;
				cnt_q[15:8]  <= rdata;
			end
			wlr_pkg::OP_RD_CLO: begin
				crc_q       <= crc_nx;
				ptr_q       <= ptr_q + 1'b1;
				cnt_q[7:0]  <= rdata;
			end
			// stored size byte is skipped, the requested size goes into the CRC
			wlr_pkg::OP_RD_RSIZE: begin
				crc_q  <= crc_nx;
				ptr_q  <= ptr_q + 1'b1;
				size_q <= in_q.read_size;
			end
			wlr_pkg::OP_SC_NEXT: begin
				base_q <= next_base;
				ptr_q  <= next_base;
				crc_q  <= wlr_pkg::CRC_INIT;
				idx_q  <= '0;
			end
			default: ;
		endcase
	end

	// control state and result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_cfg_q <= wlr_pkg::FILL_RESET;
			wcount_q   <= '0;
			rcnt_q     <= '0;
			raddr_q    <= '0;
			rlen_q     <= '0;
			valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				fill_cfg_q <= cfg_wdata;
			end
			valid_q <= 1'b0;
			case (cmd.op)
				wlr_pkg::OP_BUF: begin
					if (wcount_q <= WCW'(MAX_DATA)) begin
						wcount_q <= wcount_q + 1'b1;
					end
				end
				wlr_pkg::OP_CMT_CHK: wcount_q <= '0;
				wlr_pkg::OP_CMT_RESET: begin
					rcnt_q  <= '0;
					raddr_q <= '0;
					rlen_q  <= '0;
				end
				wlr_pkg::OP_CMT_DONE, wlr_pkg::OP_SC_NEXT: begin
					rcnt_q  <= cnt_q;
					raddr_q <= 16'(base_q);
					rlen_q  <= size_q + wlr_pkg::OVERHEAD;
				end
				wlr_pkg::OP_RD_DATA: begin
					valid_q <= 1'b1;
					res_q   <= '{data_out: rdata, status: wlr_pkg::ST_DATA, last_out: 1'b0};
				end
				wlr_pkg::OP_RD_END: begin
					valid_q <= 1'b1;
					res_q   <= '{data_out: 8'd0,
						status: (rdata == (crc_q ^ wlr_pkg::CRC_XOR)) ?
							wlr_pkg::ST_OK : wlr_pkg::ST_ERR,
						last_out: 1'b1};
				end
				wlr_pkg::OP_EMIT: begin
					valid_q <= 1'b1;
					res_q   <= '{data_out: 8'd0, status: cmd.est, last_out: 1'b1};
				end
				default: ;
			endcase
		end
	end

	assign valid  = valid_q;
	assign result = res_q;

	assign stat.cmd       = in_q.cmd;
	assign stat.last      = in_q.last_in;
	assign stat.rsize_big = in_q.read_size > 8'(MAX_DATA);
	assign stat.fill_last = ptr_q == PW'(STORE_BYTES - 1);
	assign stat.big       = (size_q > 8'(MAX_DATA)) ||
		(PW'(size_q) + PW'(wlr_pkg::OVERHEAD) > PW'(STORE_BYTES));
	assign stat.wrap      = rec_end + PW'(size_q) + PW'(wlr_pkg::OVERHEAD) > PW'(STORE_BYTES);
	assign stat.idx_done  = idx_q == size_q;
	assign stat.hdr_ok    = rdata == wlr_pkg::HDR_BYTE;
	assign stat.size_ok   = rdata <= 8'(MAX_DATA);
	assign stat.crc_ok    = rdata == (crc_q ^ wlr_pkg::CRC_XOR);
	assign stat.base_in   = base_q < PW'(STORE_BYTES);
	assign stat.cnt_zero  = rcnt_q == 16'd0;

endmodule
`default_nettype wire

@@ rtl/wlr_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wlr_ctrl
// Sequencer: walks commit, read, scan, erase and the post-reset clear.
// ----------------------------------------------------------------------------
module wlr_ctrl (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     accept,
	input  wire wlr_pkg::dp_stat_t  stat,
	output wlr_pkg::dp_cmd_t        cmd,
	output logic                    busy
);
	typedef enum logic [5:0] {
		S_CLR0, S_CLR, S_IDLE, S_DISP, S_BUF, S_CHK, S_CHK2, S_BIG,
		S_WIPE0, S_WIPE, S_WRST, S_WSET, S_WHDR, S_WCHI, S_WCLO, S_WSIZE,
		S_WDW, S_WD, S_WCRC, S_WDONE, S_OK, S_ERR,
		S_RSET, S_SSET, S_HW, S_H, S_CHW, S_CH, S_CLW, S_CL, S_RSZ,
		S_SZW, S_SZ, S_DW, S_D, S_CMP, S_BASE, S_SEND, S_ER0, S_ER
	} state_t;

	state_t state_q, nxt;
	logic   is_scan;

	assign is_scan = stat.cmd == wlr_pkg::CMD_SCAN;
	assign busy    = state_q != S_IDLE;

	always_comb begin
		nxt     = state_q;
		cmd.op  = wlr_pkg::OP_NONE;
		cmd.est = wlr_pkg::ST_OK;
		case (state_q)
			S_CLR0: begin cmd.op = wlr_pkg::OP_CLR_START; nxt = S_CLR; end
			S_CLR: begin
				cmd.op = wlr_pkg::OP_FILL;
				if (stat.fill_last) nxt = S_IDLE;
			end
			S_IDLE: if (accept) nxt = S_DISP;
			S_DISP: begin
				case (stat.cmd)
					wlr_pkg::CMD_WRITE: nxt = S_BUF;
					wlr_pkg::CMD_READ:  nxt = stat.rsize_big ? S_ERR : S_RSET;
					wlr_pkg::CMD_SCAN:  nxt = S_SSET;
					default:            nxt = S_ER0;
				endcase
			end
			S_BUF: begin
				cmd.op = wlr_pkg::OP_BUF;
				nxt    = stat.last ? S_CHK : S_IDLE;
			end
			S_CHK:  begin cmd.op = wlr_pkg::OP_CMT_CHK; nxt = S_CHK2; end
			S_CHK2: nxt = stat.big ? S_BIG : (stat.wrap ? S_WIPE0 : S_WSET);
			S_BIG: begin
				cmd.op = wlr_pkg::OP_EMIT; cmd.est = wlr_pkg::ST_BIG; nxt = S_IDLE;
			end
			S_WIPE0: begin cmd.op = wlr_pkg::OP_ERA_START; nxt = S_WIPE; end
			S_WIPE: begin
				cmd.op = wlr_pkg::OP_FILL;
				if (stat.fill_last) nxt = S_WRST;
			end
			S_WRST:  begin cmd.op = wlr_pkg::OP_CMT_RESET; nxt = S_WSET; end
			S_WSET:  begin cmd.op = wlr_pkg::OP_CMT_SETUP; nxt = S_WHDR; end
			S_WHDR:  begin cmd.op = wlr_pkg::OP_WR_HDR;    nxt = S_WCHI; end
			S_WCHI:  begin cmd.op = wlr_pkg::OP_WR_CHI;    nxt = S_WCLO; end
			S_WCLO:  begin cmd.op = wlr_pkg::OP_WR_CLO;    nxt = S_WSIZE; end
			S_WSIZE: begin cmd.op = wlr_pkg::OP_WR_SIZE;   nxt = S_WDW; end
			// buffer read settles here
			S_WDW:   nxt = stat.idx_done ? S_WCRC : S_WD;
			S_WD:    begin cmd.op = wlr_pkg::OP_WR_DATA;   nxt = S_WDW; end
			S_WCRC:  begin cmd.op = wlr_pkg::OP_WR_CRC;    nxt = S_WDONE; end
			S_WDONE: begin cmd.op = wlr_pkg::OP_CMT_DONE;  nxt = S_OK; end
			S_OK:    begin cmd.op = wlr_pkg::OP_EMIT; nxt = S_IDLE; end
			S_ERR: begin
				cmd.op = wlr_pkg::OP_EMIT; cmd.est = wlr_pkg::ST_ERR; nxt = S_IDLE;
			end
			S_RSET: begin cmd.op = wlr_pkg::OP_RD_SETUP; nxt = S_HW; end
			S_SSET: begin cmd.op = wlr_pkg::OP_SC_SETUP; nxt = S_HW; end
			S_HW:   nxt = S_H;
			S_H: begin
				if (is_scan && !stat.hdr_ok) begin
					nxt = S_SEND;
				end else begin
					cmd.op = wlr_pkg::OP_RD_HDR; nxt = S_CHW;
				end
			end
			S_CHW: nxt = S_CH;
			S_CH:  begin cmd.op = wlr_pkg::OP_RD_CHI; nxt = S_CLW; end
			S_CLW: nxt = S_CL;
			S_CL:  begin cmd.op = wlr_pkg::OP_RD_CLO; nxt = is_scan ? S_SZW : S_RSZ; end
			S_RSZ: begin cmd.op = wlr_pkg::OP_RD_RSIZE; nxt = S_DW; end
			S_SZW: nxt = S_SZ;
			S_SZ: begin
				if (!stat.size_ok) begin
					nxt = S_SEND;
				end else begin
					cmd.op = wlr_pkg::OP_SC_SIZE; nxt = S_DW;
				end
			end
			S_DW: nxt = stat.idx_done ? S_CMP : S_D;
			S_D: begin
				cmd.op = is_scan ? wlr_pkg::OP_SC_DATA : wlr_pkg::OP_RD_DATA;
				nxt    = S_DW;
			end
			S_CMP: begin
				if (!is_scan) begin
					cmd.op = wlr_pkg::OP_RD_END; nxt = S_IDLE;
				end else if (stat.crc_ok) begin
					cmd.op = wlr_pkg::OP_SC_NEXT; nxt = S_BASE;
				end else begin
					nxt = S_SEND;
				end
			end
			// also covers the read latency of the next header
			S_BASE: nxt = stat.base_in ? S_H : S_SEND;
			S_SEND: begin
				cmd.op  = wlr_pkg::OP_EMIT;
				cmd.est = stat.cnt_zero ? wlr_pkg::ST_EMPTY : wlr_pkg::ST_OK;
				nxt     = S_IDLE;
			end
			S_ER0: begin cmd.op = wlr_pkg::OP_ERA_START; nxt = S_ER; end
			S_ER: begin
				cmd.op = wlr_pkg::OP_FILL;
				if (stat.fill_last) nxt = S_OK;
			end
			default: nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR0;
		end else begin
			state_q <= nxt;
		end
	end

endmodule
`default_nettype wire

@@ rtl/wear_level_record_log_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Write byte, not last: buffered, no result. Commit: writes header, count, size,
// data and CRC, after the store is wiped first when the log wraps.
// Read: one data beat per requested byte, then a status beat.
// Scan: walks the records one after another. Erase: fills the whole store.
// The single store port, one byte per cycle, is shared by all of these.
// After reset the store is cleared to 0xFF with busy high.
// ----------------------------------------------------------------------------
// wear_level_record_log_top
// Append-only record log with CRC8 over a byte store, command interface.
// ----------------------------------------------------------------------------
module wear_level_record_log_top #(
	parameter int STORE_BYTES = wlr_pkg::STORE_BYTES_DEF,
	parameter int MAX_DATA    = wlr_pkg::MAX_DATA_DEF
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      start,
	output logic                     busy,
	input  wire wlr_pkg::in_item_t   item,
	output logic                     valid,
	output wlr_pkg::out_item_t       result,
	input  wire                      cfg_we,
	input  wire  [7:0]               cfg_wdata
);
	wlr_pkg::dp_cmd_t  cmd;
	wlr_pkg::dp_stat_t stat;
	logic              accept;

	assign accept = start && !busy;

	wlr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	wlr_dp #(
		.STORE_BYTES (STORE_BYTES),
		.MAX_DATA    (MAX_DATA)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat),
		.valid     (valid),
		.result    (result)
	);

endmodule
`default_nettype wire

@@ rtl/wlr_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wlr_checker
// Port-level checks on the record log, bound to the top level.
// ----------------------------------------------------------------------------
module wlr_checker (
	input wire                      clk,
	input wire                      arst_n,
	input wire                      start,
	input wire                      busy,
	input wire wlr_pkg::out_item_t  result,
	input wire                      valid
);
	// an accepted beat always occupies the block
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("not busy after accept");

	// a data beat is never the final one and more follows
	a_data_more: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !result.last_out |=> busy) else $error("idle inside a read");

	a_data_notlast: assert property (@(posedge clk) disable iff (!arst_n)
		valid && result.status == wlr_pkg::ST_DATA |-> !result.last_out)
		else $error("data beat marked last");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid && result.last_out |-> result.data_out == 8'd0)
		else $error("status beat carries data");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> result.status <= wlr_pkg::ST_EMPTY) else $error("bad status code");

endmodule

bind wear_level_record_log_top wlr_checker u_wlr_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.result (result),
	.valid  (valid)
);
`default_nettype wire
